/* rtl/core/lnunpk_pkg.sv */
// ----------------------------------------------------------------------------
// lnunpk_pkg: shared types and constants of the 12-bit line unpacker
// Holds the frame walk state, the per-pixel result and the register map.
// ----------------------------------------------------------------------------
`default_nettype none

package lnunpk_pkg;

  localparam int unsigned PixW   = 12;
  localparam int unsigned RowW   = 13;
  localparam int unsigned ColW   = 14;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned SecW   = 11;  // byte count within a 2048-byte pad block
  localparam int unsigned CfgAw  = 3;
  localparam int unsigned CfgDw  = 32;
  localparam int unsigned OutDw  = 40;  // 39 payload bits, padded to whole bytes

  // Register map, by word index (paddr[2])
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Byte position inside a 3-byte group
  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;

  typedef struct packed {
    logic [1:0]       byte_phase;
    logic [ByteW-1:0] held_byte;
    logic [ColW-1:0]  column_count;
    logic [RowW-1:0]  line_index;
    logic             odd_section;
    logic [SecW-1:0]  section_byte_count;
    logic [SecW-1:0]  skip_remaining;
  } walk_state_t;

  typedef struct packed {
    logic            valid;
    logic [PixW-1:0] pixel_value;
    logic [RowW-1:0] pixel_row;
    logic [ColW-1:0] pixel_col;
    logic            frame_last;
  } pixel_res_t;

endpackage

`default_nettype wire

/* rtl/core/lnunpk_core.sv */
// ----------------------------------------------------------------------------
// lnunpk_core: one-byte step of the line unpacker
// Combinational next-state and result for one accepted byte.
// ----------------------------------------------------------------------------
`default_nettype none

module lnunpk_core (
  input  wire lnunpk_pkg::walk_state_t             st,
  input  wire logic [lnunpk_pkg::ColW-1:0]         image_width,
  input  wire logic [lnunpk_pkg::RowW-1:0]         image_height,
  input  wire logic [lnunpk_pkg::ByteW-1:0]        data_byte,
  output lnunpk_pkg::walk_state_t                  st_nxt,
  output lnunpk_pkg::pixel_res_t                   res
);

  logic [lnunpk_pkg::ColW-1:0] w_even;
  logic [lnunpk_pkg::ColW-1:0] w_used;
  logic [lnunpk_pkg::RowW-1:0] h_used;
  logic [lnunpk_pkg::RowW:0]   h_plus;
  logic [lnunpk_pkg::RowW-1:0] even_lines;
  logic [lnunpk_pkg::RowW-1:0] odd_lines;
  logic [lnunpk_pkg::RowW-1:0] sec_lines;
  logic [lnunpk_pkg::ColW:0]   col_inc;
  logic [lnunpk_pkg::RowW:0]   line_inc;
  logic [lnunpk_pkg::SecW-1:0] sec_cnt;

  // Width made even, zero promoted to 2; height zero promoted to 1
  assign w_even     = {image_width[lnunpk_pkg::ColW-1:1], 1'b0};
  assign w_used     = (w_even == '0) ? lnunpk_pkg::ColW'(2) : w_even;
  assign h_used     = (image_height == '0) ? lnunpk_pkg::RowW'(1) : image_height;
  assign h_plus     = {1'b0, h_used} + (lnunpk_pkg::RowW + 1)'(1);
  assign even_lines = h_plus[lnunpk_pkg::RowW:1];
  assign odd_lines  = {1'b0, h_used[lnunpk_pkg::RowW-1:1]};
  assign sec_lines  = st.odd_section ? odd_lines : even_lines;
  assign col_inc    = {1'b0, st.column_count} + (lnunpk_pkg::ColW + 1)'(1);
  assign line_inc   = {1'b0, st.line_index} + (lnunpk_pkg::RowW + 1)'(1);
  assign sec_cnt    = st.section_byte_count + lnunpk_pkg::SecW'(1);

  always_comb begin
    st_nxt          = st;
    res.valid       = 1'b0;
    res.pixel_value = '0;
    res.pixel_row   = {st.line_index[lnunpk_pkg::RowW-2:0], st.odd_section};
    res.pixel_col   = st.column_count;
    res.frame_last  = 1'b0;

    if (st.skip_remaining != '0) begin
      // drop a padding byte
      st_nxt.skip_remaining = st.skip_remaining - lnunpk_pkg::SecW'(1);
    end else begin
      st_nxt.section_byte_count = sec_cnt;
      case (st.byte_phase)
        lnunpk_pkg::PH_SECOND: begin
          res.valid          = 1'b1;
          res.pixel_value    = {st.held_byte, data_byte[7:4]};
          st_nxt.held_byte   = {4'h0, data_byte[3:0]};
          st_nxt.byte_phase  = lnunpk_pkg::PH_THIRD;
        end
        lnunpk_pkg::PH_THIRD: begin
          res.valid          = 1'b1;
          res.pixel_value    = {st.held_byte[3:0], data_byte};
          st_nxt.held_byte   = '0;
          st_nxt.byte_phase  = lnunpk_pkg::PH_FIRST;
        end
        default: begin
          st_nxt.held_byte   = data_byte;
          st_nxt.byte_phase  = lnunpk_pkg::PH_SECOND;
        end
      endcase

      if (res.valid) begin
        if (col_inc >= {1'b0, w_used}) begin
          st_nxt.column_count = '0;
          st_nxt.line_index   = line_inc[lnunpk_pkg::RowW-1:0];
          if (line_inc >= {1'b0, sec_lines}) begin
            if (!st.odd_section && odd_lines != '0) begin
              // even section done: skip up to the next pad boundary
              st_nxt.skip_remaining     = lnunpk_pkg::SecW'(0) - sec_cnt;
              st_nxt.odd_section        = 1'b1;
              st_nxt.line_index         = '0;
              st_nxt.section_byte_count = '0;
              st_nxt.byte_phase         = lnunpk_pkg::PH_FIRST;
              st_nxt.held_byte          = '0;
            end else begin
              res.frame_last = 1'b1;
              st_nxt         = '0;
            end
          end
        end else begin
          st_nxt.column_count = col_inc[lnunpk_pkg::ColW-1:0];
        end
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/interleaved_12bit_line_unpacker_top.sv */
// ----------------------------------------------------------------------------
// interleaved_12bit_line_unpacker_top: packed 12-bit raw frame to pixels
// Byte stream in, one pixel with row, column and end-of-frame flag out.
// ----------------------------------------------------------------------------
// Takes one byte per transfer on in_ and reads the stream MSB-first as 12-bit
// samples, so every three bytes give two pixels on out_. The first
// ceil(height/2) lines land on even rows; padding up to the next 2048-byte
// boundary of the section is then dropped without a result, and the rest of
// the lines land on odd rows. out_tlast marks the final pixel of a frame, after
// which the block starts the next frame. The step logic sits between the
// state registers and a single output register, and a byte is taken in
// every cycle in which that register is empty or being drained, so the
// sustained rate is one byte per clock. Results are registered and appear
// in the cycle after the byte that completes them. image_width (address 0) and
// image_height (address 4) apply from the next byte on, also in the middle of
// a frame; the lowest width bit is ignored.
`default_nettype none

module interleaved_12bit_line_unpacker_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input byte stream
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [7:0]                        in_tdata,   // [7:0] data_byte
  // pixel stream
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [11:0] pixel_value, [24:12] pixel_row, [38:25] pixel_col, [39] zero
  output logic [lnunpk_pkg::OutDw-1:0]           out_tdata,
  output logic                                   out_tlast,  // frame_last
  // configuration
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [lnunpk_pkg::CfgAw-1:0]      cfg_paddr,
  input  wire logic [lnunpk_pkg::CfgDw-1:0]      cfg_pwdata,
  output logic [lnunpk_pkg::CfgDw-1:0]           cfg_prdata,
  output logic                                   cfg_pready
);

  lnunpk_pkg::walk_state_t st_r, st_nxt;
  lnunpk_pkg::pixel_res_t  res;

  logic [lnunpk_pkg::ColW-1:0] width_r;
  logic [lnunpk_pkg::RowW-1:0] height_r;

  logic                        out_valid_r;
  logic [lnunpk_pkg::PixW-1:0] pix_r;
  logic [lnunpk_pkg::RowW-1:0] row_r;
  logic [lnunpk_pkg::ColW-1:0] col_r;
  logic                        last_r;

  logic in_xfer;
  logic out_xfer;
  logic cfg_wr;

  // Take a byte whenever the output register is free or drains this cycle
  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;
  assign out_xfer  = out_valid_r && out_tready;

  // ---------------- configuration port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= lnunpk_pkg::ColW'(2);
      height_r <= lnunpk_pkg::RowW'(1);
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        lnunpk_pkg::REG_WIDTH:  width_r  <= cfg_pwdata[lnunpk_pkg::ColW-1:0];
        lnunpk_pkg::REG_HEIGHT: height_r <= cfg_pwdata[lnunpk_pkg::RowW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      lnunpk_pkg::REG_WIDTH:  cfg_prdata = lnunpk_pkg::CfgDw'(width_r);
      lnunpk_pkg::REG_HEIGHT: cfg_prdata = lnunpk_pkg::CfgDw'(height_r);
      default:                cfg_prdata = '0;
    endcase
  end

  // ---------------- per-byte step ----------------
  lnunpk_core u_core (
    .st           (st_r),
    .image_width  (width_r),
    .image_height (height_r),
    .data_byte    (in_tdata),
    .st_nxt       (st_nxt),
    .res          (res)
  );

  // Advance the frame walk on every accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (in_xfer) begin
      st_r <= st_nxt;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= res.valid;
    end else if (out_xfer) begin
      out_valid_r <= 1'b0;
    end
  end

  // Payload: load only when a new pixel comes out, hold otherwise
  always_ff @(posedge clk) begin
    if (in_xfer && res.valid) begin
      pix_r  <= res.pixel_value;
      row_r  <= res.pixel_row;
      col_r  <= res.pixel_col;
      last_r <= res.frame_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, col_r, row_r, pix_r};
  assign out_tlast  = last_r;

  // ---------------- assertions ----------------
  a_phase_legal : assert property (@(posedge clk) disable iff (!rst_n)
    st_r.byte_phase != 2'd3)
    else $error("byte phase left the 3-byte group");

  a_skip_in_odd : assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.skip_remaining != '0) |-> st_r.odd_section)
    else $error("padding skip outside the odd section");

  a_pixel_phase : assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && res.valid) |->
      (st_r.byte_phase == lnunpk_pkg::PH_SECOND ||
       st_r.byte_phase == lnunpk_pkg::PH_THIRD))
    else $error("pixel produced on the first byte of a group");

  a_frame_restart : assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && res.valid && res.frame_last) |=>
      (st_r == '0 && out_valid_r && out_tlast))
    else $error("frame end did not restart the walk");

endmodule

`default_nettype wire
